/* hw/rtl/mpm_pkg.sv */
// Shared types and constants for the multi-pattern prefix matcher.
// Holds edge store sizing, command and verdict codes, and interface structs.
// No dependencies.
`default_nettype none

package mpm_pkg;

  // Sizing of the edge store and of the node and symbol fields
  localparam int EDGES       = 32;
  localparam int NODE_BITS   = 5;
  localparam int SYMBOL_BITS = 16;
  localparam int SLOT_BITS   = $clog2(EDGES);
  localparam int CMD_BITS    = 2;
  localparam int SLOT_W      = 5;

  typedef logic [NODE_BITS-1:0]   node_t;
  typedef logic [SYMBOL_BITS-1:0] symbol_t;
  typedef logic [SLOT_BITS-1:0]   slot_idx_t;

  // Command codes carried by each input item
  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_MATCH   = 2'd1,
    CMD_RESTART = 2'd2
  } command_t;

  // Verdict codes returned for match items
  typedef enum logic [1:0] {
    VERDICT_UNDECIDED = 2'd0,
    VERDICT_FAILED    = 2'd1,
    VERDICT_MATCHED   = 2'd2
  } verdict_t;

  // One trie edge as held in the store
  typedef struct packed {
    logic    valid;
    node_t   node;
    symbol_t sym;
    node_t   next;
  } edge_t;

  // Result of the parallel edge lookup
  typedef struct packed {
    logic  hit;
    node_t next;
  } lookup_t;

  // Captured input item
  typedef struct packed {
    logic [CMD_BITS-1:0] command;
    logic [SLOT_W-1:0]   slot;
    edge_t               entry;
    symbol_t             symbol;
  } item_t;

endpackage

`default_nettype wire

/* hw/rtl/mpm_edge_store.sv */
// Trie edge store: register file with per-slot valid bits and a parallel
// compare of all edges against the current node and symbol.
// Depends on mpm_pkg.
`default_nettype none

module mpm_edge_store (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  mpm_pkg::slot_idx_t wr_slot,
  input  mpm_pkg::edge_t     wr_entry,
  input  mpm_pkg::node_t     cur_node,
  input  mpm_pkg::symbol_t   symbol,
  output mpm_pkg::lookup_t   lookup
);
  import mpm_pkg::*;

  logic [EDGES-1:0] valid;
  node_t            node [EDGES];
  symbol_t          sym  [EDGES];
  node_t            next [EDGES];
  logic [EDGES-1:0] hit_vec;

  // Valid bits are cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_slot] <= wr_entry.valid;
    end
  end

  // Edge payload, no reset needed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      node[wr_slot] <= wr_entry.node;
      sym[wr_slot]  <= wr_entry.sym;
      next[wr_slot] <= wr_entry.next;
    end
  end

  // Per-slot compare
  always_comb begin
    for (int k = 0; k < EDGES; k++) begin
      hit_vec[k] = valid[k] && (node[k] == cur_node) && (sym[k] == symbol);
    end
  end

  // Lowest numbered matching slot wins
  always_comb begin
    lookup.hit  = |hit_vec;
    lookup.next = '0;
    for (int k = EDGES - 1; k >= 0; k--) begin
      if (hit_vec[k]) begin
        lookup.next = next[k];
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mpm_walk.sv */
// Trie walk state: current node and decided flag, plus the verdict for
// a match item given the edge lookup result.
// Depends on mpm_pkg.
`default_nettype none

module mpm_walk (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             restart,
  input  mpm_pkg::lookup_t lookup,
  output mpm_pkg::node_t   cur_node,
  output mpm_pkg::verdict_t verdict
);
  import mpm_pkg::*;

  node_t cur_node_next;
  logic  decided;
  logic  decided_next;

  // Next walk state and verdict
  always_comb begin
    cur_node_next = cur_node;
    decided_next  = decided;
    verdict       = VERDICT_UNDECIDED;
    if (restart) begin
      cur_node_next = '0;
      decided_next  = 1'b0;
    end else if (step && !decided) begin
      if (!lookup.hit) begin
        decided_next = 1'b1;
        verdict      = VERDICT_FAILED;
      end else if (lookup.next == '0) begin
        decided_next = 1'b1;
        verdict      = VERDICT_MATCHED;
      end else begin
        cur_node_next = lookup.next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_node <= '0;
      decided  <= 1'b0;
    end else begin
      cur_node <= cur_node_next;
      decided  <= decided_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/multi_pattern_prefix_matcher_core.sv */
// Top level of the multi-pattern prefix matcher: input register, edge store,
// walk state and verdict output register.
// Depends on mpm_pkg, mpm_edge_store, mpm_walk.
//
//   channel   | handshake                   | payload
//   ----------+-----------------------------+--------------------------------
//   command   | cmd_valid / cmd_stall       | command, edge_slot, edge_node,
//             |                             | edge_symbol, edge_next,
//             |                             | edge_valid, symbol
//   verdict   | verdict_valid / verdict_stall | verdict
//
// One item per cycle sustained while no verdict is stalled. A match item
// passes through the input register, then the lookup over all edges and the
// walk update land in the verdict register. Loads and restarts pass through
// the input register, then write the edge store or update the walk state.
// Reset (rst, synchronous) clears edge valid bits, the walk state and both
// valid flags. A stalled verdict holds a pending match item in the input
// register; loads and restarts keep flowing while no match waits.
`default_nettype none

module multi_pattern_prefix_matcher_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  logic [mpm_pkg::CMD_BITS-1:0]    command,
  input  logic [mpm_pkg::SLOT_W-1:0]      edge_slot,
  input  mpm_pkg::node_t                  edge_node,
  input  mpm_pkg::symbol_t                edge_symbol,
  input  mpm_pkg::node_t                  edge_next,
  input  logic                            edge_valid,
  input  mpm_pkg::symbol_t                symbol,
  output logic                            verdict_valid,
  input  logic                            verdict_stall,
  output logic [1:0]                      verdict
);
  import mpm_pkg::*;

  item_t     item_q;
  logic      item_q_valid;
  logic      is_match;
  logic      out_free;
  logic      fire;
  logic      slot_ok;
  logic      load_en;
  node_t     cur_node;
  lookup_t   lookup;
  verdict_t  verdict_next;

  // Issue control: a match needs room in the verdict register
  assign is_match  = (item_q.command == CMD_MATCH);
  assign out_free  = !verdict_valid || !verdict_stall;
  assign fire      = item_q_valid && (!is_match || out_free);
  assign cmd_stall = item_q_valid && !fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!cmd_stall) begin
      item_q_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      item_q.command     <= command;
      item_q.slot        <= edge_slot;
      item_q.entry.valid <= edge_valid;
      item_q.entry.node  <= edge_node;
      item_q.entry.sym   <= edge_symbol;
      item_q.entry.next  <= edge_next;
      item_q.symbol      <= symbol;
    end
  end

  // Edge loads; slots beyond the store are dropped
  assign slot_ok = (32'(item_q.slot) < EDGES);
  assign load_en = fire && (item_q.command == CMD_LOAD) && slot_ok;

  mpm_edge_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (load_en),
    .wr_slot  (SLOT_BITS'(item_q.slot)),
    .wr_entry (item_q.entry),
    .cur_node (cur_node),
    .symbol   (item_q.symbol),
    .lookup   (lookup)
  );

  mpm_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .step     (fire && is_match),
    .restart  (fire && (item_q.command == CMD_RESTART)),
    .lookup   (lookup),
    .cur_node (cur_node),
    .verdict  (verdict_next)
  );

  // Verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (out_free) begin
      verdict_valid <= fire && is_match;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_match) begin
      verdict <= verdict_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mpm_checker.sv */
// Port-level checks for the multi-pattern prefix matcher core.
// Bound to multi_pattern_prefix_matcher_core; depends on mpm_pkg.
`default_nettype none

module mpm_core_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_stall,
  input logic       verdict_valid,
  input logic       verdict_stall,
  input logic [1:0] verdict
);
  import mpm_pkg::*;

  // A stalled verdict stays put
  a_verdict_hold: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict_stall |=> verdict_valid && $stable(verdict))
    else $error("verdict changed while stalled");

  // Only defined verdict codes leave the block
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (verdict == VERDICT_UNDECIDED) || (verdict == VERDICT_FAILED)
                      || (verdict == VERDICT_MATCHED))
    else $error("undefined verdict code");

  // Input backpressure only comes from a blocked verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> verdict_valid && verdict_stall)
    else $error("command stalled without a blocked verdict");

  // Reset leaves no verdict pending
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !verdict_valid)
    else $error("verdict valid right after reset");

endmodule

bind multi_pattern_prefix_matcher_core mpm_core_checker u_mpm_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_stall     (cmd_stall),
  .verdict_valid (verdict_valid),
  .verdict_stall (verdict_stall),
  .verdict       (verdict)
);

`default_nettype wire

/* tb/mpm_checker.sv */
// Scoreboard for the multi-pattern prefix matcher: watches both channels,
// predicts each verdict from its own copy of the trie and walk state, compares.
// Depends on mpm_pkg.
`default_nettype none

module mpm_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  logic                          cmd_stall,
  input  logic [mpm_pkg::CMD_BITS-1:0]  command,
  input  logic [mpm_pkg::SLOT_W-1:0]    edge_slot,
  input  mpm_pkg::node_t                edge_node,
  input  mpm_pkg::symbol_t              edge_symbol,
  input  mpm_pkg::node_t                edge_next,
  input  logic                          edge_valid,
  input  mpm_pkg::symbol_t              symbol,
  input  logic                          verdict_valid,
  input  logic                          verdict_stall,
  input  logic [1:0]                    verdict,
  output int                            mismatches,
  output int                            verdicts_owed
);
  import mpm_pkg::*;

  // Shadow trie and walk state
  edge_t    trie [EDGES];
  node_t    walk_node;
  logic     walk_over;
  verdict_t owed_q [$];
  int       errs = 0;

  assign mismatches = errs;

  // One step of the walk; lowest slot wins when several edges match
  function automatic verdict_t step_walk(symbol_t ch);
    logic  hit;
    node_t target;
    hit    = 1'b0;
    target = '0;
    if (walk_over) return VERDICT_UNDECIDED;
    for (int k = 0; k < EDGES; k++) begin
      if (!hit && trie[k].valid && trie[k].node == walk_node && trie[k].sym == ch) begin
        hit    = 1'b1;
        target = trie[k].next;
      end
    end
    if (!hit) begin
      walk_over = 1'b1;
      return VERDICT_FAILED;
    end
    if (target == '0) begin
      walk_over = 1'b1;
      return VERDICT_MATCHED;
    end
    walk_node = target;
    return VERDICT_UNDECIDED;
  endfunction

  // Compare accepted verdicts first, then fold in the accepted command item
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      foreach (trie[k]) trie[k] = '0;
      walk_node = '0;
      walk_over = 1'b0;
      owed_q.delete();
    end else begin
      if (verdict_valid && !verdict_stall) begin
        if (owed_q.size() == 0) begin
          $error("verdict: expected none, actual %0d", verdict);
          errs++;
        end else begin
          want = owed_q.pop_front();
          if (verdict !== want) begin
            $error("verdict: expected %0d, actual %0d", want, verdict);
            errs++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        case (command)
          CMD_LOAD: begin
            if (edge_slot < EDGES)
              trie[edge_slot] = '{valid: edge_valid, node: edge_node,
                                  sym: edge_symbol, next: edge_next};
          end
          CMD_MATCH: begin
            owed_q.push_back(step_walk(symbol));
          end
          CMD_RESTART: begin
            walk_node = '0;
            walk_over = 1'b0;
          end
          default: ;  // unused code: item dropped
        endcase
      end
    end
    verdicts_owed <= owed_q.size();
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench top for the multi-pattern prefix matcher: clock, reset, stimulus
// and receiver back-pressure; verdict from mpm_checker.
// Depends on mpm_pkg, multi_pattern_prefix_matcher_core, mpm_checker.
`default_nettype none

module tb;
  import mpm_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT      = 400000;
  localparam int ITEM_GOAL  = 2000;
  localparam int CALM_AFTER = 1700;
  localparam int HOLD_LEN   = 300;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  logic [CMD_BITS-1:0] command = CMD_RESTART;
  logic [SLOT_W-1:0]   edge_slot = '0;
  node_t               edge_node = '0;
  symbol_t             edge_symbol = '0;
  node_t               edge_next = '0;
  logic                edge_valid = 1'b0;
  symbol_t             symbol = '0;
  logic                verdict_valid;
  logic                verdict_stall = 1'b0;
  logic [1:0]          verdict;
  int                  mismatches;
  int                  verdicts_owed;

  // Stimulus controls shared with the receiver process
  int   items_sent = 0;
  int   idle_pct = 10;
  bit   quiet = 1'b0;
  bit   hold_off_req = 1'b0;
  int   cycle_count = 0;

  // Pattern bookkeeping for generating walks that go deep into the trie
  symbol_t     alpha [8];
  symbol_t     pat_syms [6][6];
  int          pat_len [6];
  int          pat_count;
  logic [4:0]  slot_ptr = '0;
  node_t       node_ptr = '0;

  always #10 clk = ~clk;

  multi_pattern_prefix_matcher_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .edge_slot    (edge_slot),
    .edge_node    (edge_node),
    .edge_symbol  (edge_symbol),
    .edge_next    (edge_next),
    .edge_valid   (edge_valid),
    .symbol       (symbol),
    .verdict_valid(verdict_valid),
    .verdict_stall(verdict_stall),
    .verdict      (verdict)
  );

  mpm_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .edge_slot    (edge_slot),
    .edge_node    (edge_node),
    .edge_symbol  (edge_symbol),
    .edge_next    (edge_next),
    .edge_valid   (edge_valid),
    .symbol       (symbol),
    .verdict_valid(verdict_valid),
    .verdict_stall(verdict_stall),
    .verdict      (verdict),
    .mismatches   (mismatches),
    .verdicts_owed(verdicts_owed)
  );

  // Offer one item, wait for it to be taken, then maybe go idle for a burst
  task automatic send_item(input logic [CMD_BITS-1:0] op, input logic [4:0] slot,
                           input node_t src, input symbol_t label, input node_t dst,
                           input logic live, input symbol_t ch);
    cmd_valid   <= 1'b1;
    command     <= op;
    edge_slot   <= slot;
    edge_node   <= src;
    edge_symbol <= label;
    edge_next   <= dst;
    edge_valid  <= live;
    symbol      <= ch;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (op != CMD_UNUSED) items_sent++;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic load_edge(input logic [4:0] slot, input node_t src, input symbol_t label,
                           input node_t dst, input logic live);
    send_item(CMD_LOAD, slot, src, label, dst, live, symbol_t'($urandom));
  endtask

  task automatic match_char(input symbol_t ch);
    send_item(CMD_MATCH, 5'($urandom), node_t'($urandom), symbol_t'($urandom),
              node_t'($urandom), 1'($urandom), ch);
  endtask

  task automatic restart_walk();
    send_item(CMD_RESTART, 5'($urandom), node_t'($urandom), symbol_t'($urandom),
              node_t'($urandom), 1'($urandom), symbol_t'($urandom));
  endtask

  // Any command code with random fields
  task automatic send_noise();
    send_item(CMD_BITS'($urandom), 5'($urandom), node_t'($urandom), symbol_t'($urandom),
              node_t'($urandom), 1'($urandom), symbol_t'($urandom));
  endtask

  // Load a fresh set of patterns as chains of edges from the root
  task automatic load_patterns();
    node_t src;
    node_t dst;
    pat_count = $urandom_range(2, 6);
    for (int p = 0; p < pat_count; p++) begin
      pat_len[p] = $urandom_range(1, 6);
      src = '0;
      for (int i = 0; i < pat_len[p]; i++) begin
        pat_syms[p][i] = alpha[$urandom_range(0, 7)];
        if (i == pat_len[p] - 1) begin
          dst = '0;
        end else begin
          node_ptr = (node_ptr == '1) ? node_t'(1) : node_ptr + 1'b1;
          dst = node_ptr;
        end
        load_edge(slot_ptr, src, pat_syms[p][i], dst, 1'b1);
        slot_ptr++;
        src = dst;
      end
      if ($urandom_range(0, 9) == 0) begin
        load_edge(5'($urandom), node_t'($urandom), alpha[$urandom_range(0, 7)],
                  node_t'($urandom), 1'($urandom));
      end
    end
  endtask

  // Walk the loaded patterns, sometimes broken or run past the decision
  task automatic run_walks(input int count);
    int p;
    int bad;
    repeat (count) begin
      p = $urandom_range(0, pat_count - 1);
      if ($urandom_range(0, 9) != 0) restart_walk();
      bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, pat_len[p] - 1) : -1;
      for (int i = 0; i < pat_len[p]; i++) begin
        match_char((i == bad) ? symbol_t'($urandom) : pat_syms[p][i]);
      end
      repeat ($urandom_range(0, 2)) match_char(alpha[$urandom_range(0, 7)]);
      if ($urandom_range(0, 9) == 0) send_noise();
    end
  endtask

  // Receiver back-pressure: random bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        verdict_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        verdict_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        verdict_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        verdict_stall <= 1'b0;
      end
    end
  end

  // Cycle limit
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: errors");
    $finish;
  end

  // Main stimulus
  initial begin
    int phase;
    phase = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty store fails, then stays undecided until restart
    match_char(16'h0000);
    match_char(16'hFFFF);
    restart_walk();
    // Extremes of node and symbol; slot 1 duplicates slot 0 and must lose
    load_edge(5'd0, 5'd0, 16'hFFFF, 5'd31, 1'b1);
    load_edge(5'd1, 5'd0, 16'hFFFF, 5'd0, 1'b1);
    load_edge(5'd31, 5'd31, 16'h0000, 5'd0, 1'b1);
    match_char(16'hFFFF);
    match_char(16'h0000);
    match_char(16'h0000);
    restart_walk();
    match_char(16'h1234);
    // Unused command is dropped
    send_item(CMD_UNUSED, 5'd31, 5'd31, 16'hFFFF, 5'd31, 1'b1, 16'hFFFF);
    // Clearing slot 0 exposes slot 1
    restart_walk();
    load_edge(5'd0, 5'd0, 16'hFFFF, 5'd31, 1'b0);
    match_char(16'hFFFF);
    restart_walk();
    load_edge(5'd21, 5'd10, 16'hA5A5, 5'd21, 1'b1);
    match_char(16'h5A5A);
    restart_walk();

    // Random phases: new trie, then walks over it
    while (items_sent < ITEM_GOAL) begin
      phase++;
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 5;
        default: idle_pct = 25;
      endcase
      foreach (alpha[i]) alpha[i] = symbol_t'($urandom);
      if ($urandom_range(0, 3) == 0) alpha[0] = 16'h0000;
      if ($urandom_range(0, 3) == 0) alpha[1] = 16'hFFFF;
      load_patterns();
      if (phase == 3) hold_off_req = 1'b1;
      run_walks($urandom_range(8, 20));
      if (items_sent >= CALM_AFTER) quiet = 1'b1;
    end
    cmd_valid <= 1'b0;

    // Drain
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
